@@ rtl/core/sfr_pkg.sv @@
// Shared types, symbol codes and the CRC-8 byte update for the stuffed frame receiver.
package sfr_pkg;

	localparam logic [7:0] SYM_START = 8'h73;
	localparam logic [7:0] SYM_BOUND = 8'h55;
	localparam logic [7:0] SYM_ESC55 = 8'h11;
	localparam logic [7:0] SYM_ESC73 = 8'h22;
	localparam logic [7:0] CRC_POLY  = 8'hA9;
	localparam logic [7:0] CRC_TOP   = 8'h80;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_SYNC = 2'd1,
		PH_BODY = 2'd2,
		PH_ESC  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_CRC   = 3'd1,
		ST_ESC   = 3'd2,
		ST_SHORT = 3'd3,
		ST_OVER  = 3'd4
	} status_t;

	// MSB-first CRC-8, one byte, eight shift steps
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/sfr_if.sv @@
// Valid/ready channel interfaces for the raw byte input and the decoded result output.
interface sfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       frame_end;
	logic [2:0] frame_status;

	modport source (output valid, output body_byte, output frame_end, output frame_status,
		input ready);
	modport sink   (input valid, input body_byte, input frame_end, input frame_status,
		output ready);
endinterface

@@ rtl/core/stuffed_frame_receiver_crc8_core.sv @@
// Byte-stuffed frame receiver with CRC-8 check: top level.
//
// Usage:
//   rx  : raw line bytes, one per transfer. Idle bytes between frames are dropped.
//   res : one result per decoded body byte (frame_end = 0) and one end result per
//         frame (frame_end = 1, frame_status = ok / crc / bad escape / short /
//         overflow). Bytes that open a frame or start an escape give no result.
//   An rx transfer first lands in the input register; the decode and CRC update
//   then land in the result register. Throughput is one byte per cycle while
//   res does not stall; the per-byte work is a single pass of unstuffing plus
//   an eight-step CRC-8 update.
//   When res stalls, the result register holds and the input register fills;
//   rx.ready then drops until the pending result is transferred. A byte that
//   yields no result still waits for the result register to be free.
//   MAX_FRAME bounds the raw frame length, header and closing byte included.
//   Reset empties both registers and puts the decoder back into hunting for the
//   start byte with a cleared CRC and byte count.
module stuffed_frame_receiver_crc8_core #(
	parameter int MAX_FRAME = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	sfr_rx_if.sink           rx,
	sfr_res_if.source        res
);

	localparam int CW = $clog2(MAX_FRAME + 1);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	// decoder state
	sfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  held_q, held_d;
	logic        held_valid_q, held_valid_d;
	logic [CW-1:0] count_q, count_d;
	logic        esc_err_q, esc_err_d;

	// result register
	logic        res_valid_q;
	logic [7:0]  res_byte_q;
	logic        res_end_q;
	sfr_pkg::status_t res_status_q;

	logic        emit;
	logic [7:0]  emit_byte;
	logic        emit_end;
	sfr_pkg::status_t emit_status;

	assign adv      = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sfr_pkg::PH_HUNT;
			crc_q        <= 8'h00;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			count_q      <= '0;
			esc_err_q    <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_d;
			crc_q        <= crc_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			count_q      <= count_d;
			esc_err_q    <= esc_err_d;
		end
	end

	always_comb begin
		logic       do_body;
		logic [7:0] body_val;
		logic       do_close;
		logic       close_bad;
		logic       do_clear;

		do_body     = 1'b0;
		body_val    = byte_s1;
		do_close    = 1'b0;
		close_bad   = 1'b0;
		do_clear    = 1'b0;

		phase_d      = phase_q;
		crc_d        = crc_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		count_d      = count_q;
		esc_err_d    = esc_err_q;

		emit        = 1'b0;
		emit_byte   = 8'h00;
		emit_end    = 1'b0;
		emit_status = sfr_pkg::ST_OK;

		unique case (phase_q)
			sfr_pkg::PH_HUNT: begin
				if (byte_s1 == sfr_pkg::SYM_START) begin
					do_clear = 1'b1;
					phase_d  = sfr_pkg::PH_SYNC;
				end
			end
			sfr_pkg::PH_SYNC: begin
				if (byte_s1 == sfr_pkg::SYM_BOUND) begin
					phase_d = sfr_pkg::PH_BODY;
					count_d = CW'(2);
				end else begin
					do_clear = 1'b1;
					phase_d  = sfr_pkg::PH_HUNT;
				end
			end
			sfr_pkg::PH_BODY,
			sfr_pkg::PH_ESC: begin
				if (count_q >= CW'(MAX_FRAME)) begin
					emit        = 1'b1;
					emit_end    = 1'b1;
					emit_status = sfr_pkg::ST_OVER;
					do_clear    = 1'b1;
					phase_d     = sfr_pkg::PH_HUNT;
				end else begin
					count_d = count_q + CW'(1);
					if (phase_q == sfr_pkg::PH_ESC) begin
						phase_d = sfr_pkg::PH_BODY;
						case (byte_s1)
							sfr_pkg::SYM_BOUND: begin
								do_close  = 1'b1;
								close_bad = 1'b1;
							end
							sfr_pkg::SYM_ESC55: begin
								do_body  = 1'b1;
								body_val = sfr_pkg::SYM_BOUND;
							end
							sfr_pkg::SYM_ESC73: begin
								do_body  = 1'b1;
								body_val = sfr_pkg::SYM_START;
							end
							default: begin
								esc_err_d = 1'b1;
							end
						endcase
					end else begin
						case (byte_s1)
							sfr_pkg::SYM_BOUND: do_close = 1'b1;
							sfr_pkg::SYM_START: phase_d = sfr_pkg::PH_ESC;
							default: do_body = 1'b1;
						endcase
					end
				end
			end
			default: begin
				phase_d = sfr_pkg::PH_HUNT;
			end
		endcase

		if (do_body) begin
			// the previously held byte is now known not to be the trailing CRC
			if (held_valid_q) begin
				crc_d = sfr_pkg::crc8_byte(crc_q, held_q);
			end
			held_d       = body_val;
			held_valid_d = 1'b1;
			emit         = 1'b1;
			emit_byte    = body_val;
		end

		if (do_close) begin
			emit     = 1'b1;
			emit_end = 1'b1;
			if (close_bad || esc_err_q) begin
				emit_status = sfr_pkg::ST_ESC;
			end else if (!held_valid_q) begin
				emit_status = sfr_pkg::ST_SHORT;
			end else if (crc_q != held_q) begin
				emit_status = sfr_pkg::ST_CRC;
			end else begin
				emit_status = sfr_pkg::ST_OK;
			end
			do_clear = 1'b1;
			phase_d  = sfr_pkg::PH_HUNT;
		end

		if (do_clear) begin
			crc_d        = 8'h00;
			held_d       = 8'h00;
			held_valid_d = 1'b0;
			esc_err_d    = 1'b0;
			count_d      = (phase_d == sfr_pkg::PH_SYNC) ? CW'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= emit;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_byte_q   <= emit_byte;
			res_end_q    <= emit_end;
			res_status_q <= emit_status;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.body_byte    = res_byte_q;
	assign res.frame_end    = res_end_q;
	assign res.frame_status = res_status_q;

endmodule

@@ rtl/core/sfr_checker.sv @@
// Port-level checks for the stuffed frame receiver, bound to the top level.
module sfr_checker (
	input  logic      clk,
	input  logic      arst_n,
	sfr_rx_if.sink    rx,
	sfr_res_if.source res
);

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_end |-> res.body_byte == 8'h00)
		else $error("end result carries a nonzero body byte");

	a_body_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.frame_end |-> res.frame_status == sfr_pkg::ST_OK)
		else $error("body byte result carries a status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_end |-> res.frame_status <= sfr_pkg::ST_OVER)
		else $error("undefined frame status");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.body_byte)
			&& $stable(res.frame_end) && $stable(res.frame_status))
		else $error("stalled result changed");

	// checks that a fresh result traces back to an earlier input transfer
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(rx.valid && rx.ready, 2))
		else $error("result without a matching input transfer");

endmodule

bind stuffed_frame_receiver_crc8_core sfr_checker u_sfr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.rx     (rx),
	.res    (res)
);
